### design/tsit_pkg.sv
// Shared types, operation codes and constants of the split interval timer.
`default_nettype none
package tsit_pkg;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] timeout_us;
    logic [31:0] hw_count;
  } tsit_in_t;

  typedef struct packed {
    logic        start_counter;
    logic        stop_counter;
    logic [31:0] reload_ticks;
    logic        expired;
    logic [31:0] elapsed_us;
    logic        invalid;
  } tsit_out_t;

  typedef struct packed {
    logic [19:0] tick_freq_hz;
    logic [31:0] counter_limit;
    logic        one_shot;
    logic        counts_down;
  } tsit_cfg_t;

  // Commands carried by a request.
  localparam logic [1:0] CMD_SET  = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_FREQ  = 2'd0;
  localparam logic [1:0] REG_LIMIT = 2'd1;
  localparam logic [1:0] REG_ONE   = 2'd2;
  localparam logic [1:0] REG_DOWN  = 2'd3;

  localparam logic [31:0] USEC_PER_SEC = 32'd1000000;
  localparam logic [31:0] SEARCH_DIV   = 32'd5;

  // Reciprocal of SEARCH_DIV: (x * DIV5_RECIP) >> 34 equals x / 5 for any 32-bit x.
  localparam logic [31:0] DIV5_RECIP   = 32'hCCCC_CCCD;

  // Datapath operations issued by the controller.
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NONE     = 5'd0;
  localparam logic [OP_W-1:0] OP_LOAD     = 5'd1;
  localparam logic [OP_W-1:0] OP_DIV_TP   = 5'd2;
  localparam logic [OP_W-1:0] OP_DIV_CNT  = 5'd3;
  localparam logic [OP_W-1:0] OP_DIV_LIM  = 5'd4;
  localparam logic [OP_W-1:0] OP_DIV_I    = 5'd6;
  localparam logic [OP_W-1:0] OP_DIV_BEST = 5'd7;
  localparam logic [OP_W-1:0] OP_DIV_PT   = 5'd8;
  localparam logic [OP_W-1:0] OP_GET_TP   = 5'd9;
  localparam logic [OP_W-1:0] OP_GET_CNT  = 5'd10;
  localparam logic [OP_W-1:0] OP_GET_LIM  = 5'd11;
  localparam logic [OP_W-1:0] OP_GET_BND  = 5'd12;
  localparam logic [OP_W-1:0] OP_GET_I    = 5'd13;
  localparam logic [OP_W-1:0] OP_GET_BEST = 5'd14;
  localparam logic [OP_W-1:0] OP_GET_PT   = 5'd15;
  localparam logic [OP_W-1:0] OP_SMALL    = 5'd16;
  localparam logic [OP_W-1:0] OP_FAIL     = 5'd17;
  localparam logic [OP_W-1:0] OP_SET_OUT  = 5'd18;
  localparam logic [OP_W-1:0] OP_TICK     = 5'd19;
  localparam logic [OP_W-1:0] OP_R_M1     = 5'd20;
  localparam logic [OP_W-1:0] OP_R_M2     = 5'd21;
  localparam logic [OP_W-1:0] OP_R_OUT    = 5'd22;
  localparam logic [OP_W-1:0] OP_ZERO_OUT = 5'd23;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } tsit_ctl_t;

  typedef struct packed {
    logic       div_done;
    logic       count_lt_lim;
    logic       rem_zero;
    logic       rem_le1;
    logic       i_lt_bound;
    logic       best_zero;
    logic       out_free;
    logic       counts_down;
    logic [1:0] cmd;
  } tsit_sts_t;

endpackage
`default_nettype wire

### design/timeout_split_interval_timer.sv
// Top level of the split interval timer: configuration registers and units.
//
// Requests enter on in_valid/in_ready and carry a command: set timeout,
// counter period tick or read elapsed time. Each request gives exactly one
// result on out_valid/out_ready, held in an output register.
// Configuration is written through cfg_we/cfg_addr/cfg_wdata. The user must
// write it only while idle; the block itself does not enforce this.
// A set timeout ends in one of three ways: the count fits under the limit,
// it divides evenly by it, or the least-remainder search runs. A read in
// down-count mode adds a division. Each division goes through the shared
// 32-step serial divider.
// One request is in work at a time; the next is accepted once the result
// is written, even while that result still waits in the output register.
// A stalled receiver holds the result; a request done meanwhile waits
// for the output register to free up.
// Reset is synchronous: configuration returns to its reset values and
// the timer state is cleared.
`default_nettype none
module timeout_split_interval_timer (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire tsit_pkg::tsit_in_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output tsit_pkg::tsit_out_t      out_data,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_addr,
  input  wire logic [31:0]         cfg_wdata
);
  import tsit_pkg::*;

  tsit_cfg_t cfg_r;
  tsit_ctl_t ctl;
  tsit_sts_t sts;

  // Configuration register file.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tick_freq_hz  <= 20'd1000000;
      cfg_r.counter_limit <= 32'd65535;
      cfg_r.one_shot      <= 1'b0;
      cfg_r.counts_down   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_FREQ:  cfg_r.tick_freq_hz  <= cfg_wdata[19:0];
        REG_LIMIT: cfg_r.counter_limit <= cfg_wdata;
        REG_ONE:   cfg_r.one_shot      <= cfg_wdata[0];
        REG_DOWN:  cfg_r.counts_down   <= cfg_wdata[0];
        default:   ;
      endcase
    end
  end

  tsit_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_data.command),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  tsit_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .ctl       (ctl),
    .in_data   (in_data),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );
endmodule
`default_nettype wire

### design/tsit_div.sv
// Serial restoring divider, one quotient bit per cycle.
`default_nettype none
module tsit_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      quot,
  output logic [31:0]      rem
);
  logic [31:0] q_r, q_nxt, r_r, r_nxt, d_r, d_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [32:0] trial;

  // One shift and trial subtract per cycle.
  always_comb begin
    q_nxt    = q_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {r_r, q_r[31]} - {1'b0, d_r};
    if (start) begin
      q_nxt    = dividend;
      r_nxt    = '0;
      d_nxt    = divisor;
      cnt_nxt  = 6'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[32]) begin
        r_nxt = trial[31:0];
        q_nxt = {q_r[30:0], 1'b1};
      end else begin
        r_nxt = {r_r[30:0], q_r[31]};
        q_nxt = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = r_r;
endmodule
`default_nettype wire

### design/tsit_dp.sv
// Datapath: timer state, split search registers, shared divider and multiplier.
`default_nettype none
module tsit_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire tsit_pkg::tsit_cfg_t cfg,
  input  wire tsit_pkg::tsit_ctl_t ctl,
  input  wire tsit_pkg::tsit_in_t  in_data,
  output tsit_pkg::tsit_sts_t      sts,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output tsit_pkg::tsit_out_t      out_data
);
  import tsit_pkg::*;

  logic [1:0]  cmd_r;
  logic [31:0] timeout_r, hw_r;
  logic [19:0] tp_r;
  logic [31:0] count_r, i_r, best_r, best_err_r, bound_r, c_r, acc_r, prod_r;
  logic [31:0] total_r, left_r, ovp_r, period_r, reload_r;
  tsit_out_t   out_r, out_nxt;
  logic        out_valid_r;

  logic [31:0] lim, freq, tp32;
  logic        div_start, div_done;
  logic [31:0] div_a, div_b, div_q, div_rm;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [31:0] mul_lo, tick_left;
  logic        out_free, out_load;

  assign lim  = (cfg.counter_limit == 32'd0) ? 32'd1 : cfg.counter_limit;
  assign freq = (cfg.tick_freq_hz == 20'd0) ? 32'd1 : {12'd0, cfg.tick_freq_hz};
  assign tp32 = {12'd0, tp_r};

  // Divider operand selection.
  always_comb begin
    div_start = 1'b1;
    div_a     = count_r;
    div_b     = 32'd1;
    unique case (ctl.op)
      OP_DIV_TP:   begin div_a = USEC_PER_SEC; div_b = freq; end
      OP_DIV_CNT:  begin div_a = timeout_r;    div_b = tp32; end
      OP_DIV_LIM:  div_b = lim;
      OP_DIV_I:    div_b = i_r;
      OP_DIV_BEST: div_b = best_r;
      OP_DIV_PT:   begin div_a = period_r;     div_b = tp32; end
      default:     div_start = 1'b0;
    endcase
  end

  tsit_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_rm)
  );

  // Shared multiplier; its product is used only to load registers.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctl.op)
      OP_SMALL:    begin mul_a = count_r; mul_b = tp32;       end
      OP_GET_LIM:  begin mul_a = lim;     mul_b = tp32;       end
      OP_GET_BND:  begin mul_a = count_r; mul_b = DIV5_RECIP; end
      OP_GET_BEST: begin mul_a = div_q;   mul_b = tp32;       end
      OP_R_M1:     begin mul_a = total_r; mul_b = period_r;   end
      OP_R_M2:     begin mul_a = c_r;     mul_b = tp32;       end
      default:     ;
    endcase
  end
  assign mul_p     = mul_a * mul_b;
  assign mul_lo    = mul_p[31:0];
  assign tick_left = left_r - 32'd1;
  assign out_free  = !out_valid_r || out_ready;
  assign out_load  = (ctl.op == OP_SET_OUT) || (ctl.op == OP_TICK) ||
                     (ctl.op == OP_R_OUT) || (ctl.op == OP_ZERO_OUT);

  // Result word written into the output register.
  always_comb begin
    out_nxt = '0;
    unique case (ctl.op)
      OP_SET_OUT: begin
        out_nxt.stop_counter  = 1'b1;
        out_nxt.invalid       = (left_r == 32'd0);
        out_nxt.start_counter = (left_r != 32'd0);
        out_nxt.reload_ticks  = (left_r == 32'd0) ? 32'd0 : reload_r;
      end
      OP_TICK: begin
        out_nxt.expired      = (tick_left == 32'd0);
        out_nxt.stop_counter = (tick_left == 32'd0) && cfg.one_shot;
      end
      OP_R_OUT: out_nxt.elapsed_us = acc_r + prod_r;
      default:  ;
    endcase
  end

  // Per-operation register updates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      left_r      <= '0;
      ovp_r       <= '0;
      period_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
        out_r       <= out_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (ctl.op)
        OP_LOAD: begin
          cmd_r     <= in_data.command;
          timeout_r <= in_data.timeout_us;
          hw_r      <= in_data.hw_count;
        end
        OP_GET_TP: begin
          tp_r <= (div_q == 32'd0) ? 20'd1 : div_q[19:0];
          c_r  <= hw_r;
        end
        OP_GET_CNT: count_r <= (div_q == 32'd0) ? 32'd1 : div_q;
        OP_SMALL: begin
          ovp_r    <= 32'd1;
          left_r   <= 32'd1;
          period_r <= mul_lo;
          reload_r <= count_r;
        end
        OP_GET_LIM: begin
          if (div_rm == 32'd0) begin
            ovp_r    <= div_q;
            left_r   <= div_q;
            period_r <= mul_lo;
            reload_r <= lim;
          end else begin
            i_r        <= div_q + 32'd1;
            best_err_r <= div_q + 32'd1;
            best_r     <= '0;
          end
        end
        // Search bound count / 5 through the reciprocal product.
        OP_GET_BND: bound_r <= {2'b00, mul_p[63:34]};
        OP_GET_I: begin
          if (div_rm <= 32'd1) begin
            best_r <= i_r;
          end else begin
            if (div_rm < best_err_r) begin
              best_err_r <= div_rm;
              best_r     <= i_r;
            end
            i_r <= i_r + 32'd1;
          end
        end
        OP_FAIL: begin
          ovp_r    <= '0;
          left_r   <= '0;
          period_r <= '0;
          reload_r <= '0;
        end
        OP_GET_BEST: begin
          ovp_r    <= best_r;
          left_r   <= best_r;
          period_r <= mul_lo;
          reload_r <= div_q;
        end
        OP_GET_PT: c_r <= div_q - hw_r;
        OP_R_M1:   acc_r <= mul_lo;
        OP_R_M2:   prod_r <= mul_lo;
        OP_SET_OUT: total_r <= '0;
        OP_TICK: begin
          if (tick_left == 32'd0) begin
            left_r  <= ovp_r;
            total_r <= '0;
          end else begin
            left_r  <= tick_left;
            total_r <= total_r + 32'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Status toward the controller.
  always_comb begin
    sts.div_done     = div_done;
    sts.count_lt_lim = (count_r < lim);
    sts.rem_zero     = (div_rm == 32'd0);
    sts.rem_le1      = (div_rm <= 32'd1);
    sts.i_lt_bound   = (i_r < bound_r);
    sts.best_zero    = (best_r == 32'd0);
    sts.out_free     = out_free;
    sts.counts_down  = cfg.counts_down;
    sts.cmd          = cmd_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
endmodule
`default_nettype wire

### design/tsit_ctrl.sv
// Controller: sequences divisions, the divisor search and result writes.
`default_nettype none
module tsit_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic [1:0]          in_cmd,
  output logic                     in_ready,
  input  wire tsit_pkg::tsit_sts_t sts,
  output tsit_pkg::tsit_ctl_t      ctl
);
  import tsit_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_TP_S   = 5'd1;
  localparam logic [4:0] S_TP_W   = 5'd2;
  localparam logic [4:0] S_TP_G   = 5'd3;
  localparam logic [4:0] S_CNT_S  = 5'd4;
  localparam logic [4:0] S_CNT_W  = 5'd5;
  localparam logic [4:0] S_CNT_G  = 5'd6;
  localparam logic [4:0] S_CHK    = 5'd7;
  localparam logic [4:0] S_LIM_S  = 5'd8;
  localparam logic [4:0] S_LIM_W  = 5'd9;
  localparam logic [4:0] S_LIM_G  = 5'd10;
  localparam logic [4:0] S_BND    = 5'd11;
  localparam logic [4:0] S_LOOP   = 5'd14;
  localparam logic [4:0] S_I_S    = 5'd15;
  localparam logic [4:0] S_I_W    = 5'd16;
  localparam logic [4:0] S_I_G    = 5'd17;
  localparam logic [4:0] S_FIN    = 5'd18;
  localparam logic [4:0] S_BEST_S = 5'd19;
  localparam logic [4:0] S_BEST_W = 5'd20;
  localparam logic [4:0] S_BEST_G = 5'd21;
  localparam logic [4:0] S_SOUT   = 5'd22;
  localparam logic [4:0] S_PT_S   = 5'd23;
  localparam logic [4:0] S_PT_W   = 5'd24;
  localparam logic [4:0] S_PT_G   = 5'd25;
  localparam logic [4:0] S_M1     = 5'd26;
  localparam logic [4:0] S_M2     = 5'd27;
  localparam logic [4:0] S_ROUT   = 5'd28;
  localparam logic [4:0] S_TICK   = 5'd29;
  localparam logic [4:0] S_ZERO   = 5'd30;

  logic [4:0] state_r, state_nxt;

  // Next state and the operation issued in each state.
  always_comb begin
    state_nxt = state_r;
    ctl.op    = OP_NONE;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.op = OP_LOAD;
          priority if (in_cmd == CMD_SET || in_cmd == CMD_READ) state_nxt = S_TP_S;
          else if (in_cmd == CMD_TICK) state_nxt = S_TICK;
          else state_nxt = S_ZERO;
        end
      end
      S_TP_S: begin ctl.op = OP_DIV_TP; state_nxt = S_TP_W; end
      S_TP_W: if (sts.div_done) state_nxt = S_TP_G;
      S_TP_G: begin
        ctl.op = OP_GET_TP;
        priority if (sts.cmd == CMD_SET) state_nxt = S_CNT_S;
        else if (sts.counts_down) state_nxt = S_PT_S;
        else state_nxt = S_M1;
      end
      S_CNT_S: begin ctl.op = OP_DIV_CNT; state_nxt = S_CNT_W; end
      S_CNT_W: if (sts.div_done) state_nxt = S_CNT_G;
      S_CNT_G: begin ctl.op = OP_GET_CNT; state_nxt = S_CHK; end
      S_CHK: begin
        if (sts.count_lt_lim) begin
          ctl.op    = OP_SMALL;
          state_nxt = S_SOUT;
        end else begin
          state_nxt = S_LIM_S;
        end
      end
      S_LIM_S: begin ctl.op = OP_DIV_LIM; state_nxt = S_LIM_W; end
      S_LIM_W: if (sts.div_done) state_nxt = S_LIM_G;
      S_LIM_G: begin
        ctl.op    = OP_GET_LIM;
        state_nxt = sts.rem_zero ? S_SOUT : S_BND;
      end
      S_BND:   begin ctl.op = OP_GET_BND; state_nxt = S_LOOP; end
      S_LOOP:  state_nxt = sts.i_lt_bound ? S_I_S : S_FIN;
      S_I_S:   begin ctl.op = OP_DIV_I; state_nxt = S_I_W; end
      S_I_W:   if (sts.div_done) state_nxt = S_I_G;
      S_I_G: begin
        ctl.op    = OP_GET_I;
        state_nxt = sts.rem_le1 ? S_FIN : S_LOOP;
      end
      S_FIN: begin
        if (sts.best_zero) begin
          ctl.op    = OP_FAIL;
          state_nxt = S_SOUT;
        end else begin
          state_nxt = S_BEST_S;
        end
      end
      S_BEST_S: begin ctl.op = OP_DIV_BEST; state_nxt = S_BEST_W; end
      S_BEST_W: if (sts.div_done) state_nxt = S_BEST_G;
      S_BEST_G: begin ctl.op = OP_GET_BEST; state_nxt = S_SOUT; end
      S_SOUT: if (sts.out_free) begin ctl.op = OP_SET_OUT; state_nxt = S_IDLE; end
      S_PT_S: begin ctl.op = OP_DIV_PT; state_nxt = S_PT_W; end
      S_PT_W: if (sts.div_done) state_nxt = S_PT_G;
      S_PT_G: begin ctl.op = OP_GET_PT; state_nxt = S_M1; end
      S_M1:   begin ctl.op = OP_R_M1; state_nxt = S_M2; end
      S_M2:   begin ctl.op = OP_R_M2; state_nxt = S_ROUT; end
      S_ROUT: if (sts.out_free) begin ctl.op = OP_R_OUT; state_nxt = S_IDLE; end
      S_TICK: if (sts.out_free) begin ctl.op = OP_TICK; state_nxt = S_IDLE; end
      S_ZERO: if (sts.out_free) begin ctl.op = OP_ZERO_OUT; state_nxt = S_IDLE; end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule
`default_nettype wire

### design/tsit_checker.sv
// Port-level checks of the split interval timer and their binding.
`default_nettype none
module tsit_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire tsit_pkg::tsit_out_t out_data
);
  // A held result does not change until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Only one request is in work at a time.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // A restart never comes with a failed split or an expiry.
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.start_counter && out_data.invalid) &&
                  !(out_data.start_counter && out_data.expired))
    else $error("conflicting result flags");
endmodule

bind timeout_split_interval_timer tsit_checker u_tsit_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

### tb/timeout_split_interval_timer_tb.sv
// Self-checking testbench of the split interval timer with its own timer predictor.
`default_nettype none
module timeout_split_interval_timer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tsit_pkg::*;

  localparam int MAX_TRIES   = 40;
  localparam int CYCLE_LIMIT = 20000000;
  localparam int ITEMS_PER_PHASE = 290;
  localparam logic [1:0] CMD_BAD = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  tsit_in_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  tsit_out_t   out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = REG_FREQ;
  logic [31:0] cfg_wdata = '0;

  // Predicted configuration and timer state.
  logic [19:0] freq_hz;
  logic [31:0] limit;
  logic        one_shot, counts_down;
  logic [31:0] ovf_total, ovf_left, ovf_per_timeout, period_us;

  tsit_out_t pending_results[$];
  int        mismatches = 0;
  int        cycles = 0;
  logic      send_gaps = 1'b1;
  logic      recv_stalls = 1'b1;

  timeout_split_interval_timer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout_split_interval_timer_tb NOT OK");
      $finish;
    end
  end

  function automatic logic [31:0] tick_period();
    logic [31:0] f, t;
    f = (freq_hz == 0) ? 32'd1 : {12'd0, freq_hz};
    t = USEC_PER_SEC / f;
    return (t == 0) ? 32'd1 : t;
  endfunction

  function automatic logic [31:0] eff_limit();
    return (limit == 0) ? 32'd1 : limit;
  endfunction

  // Least-remainder divisor search; with a nonzero cap it gives up (returns 0)
  // once more than cap divisors would be tried.
  function automatic logic [31:0] find_divisor(input logic [31:0] count, input logic [31:0] lim,
                                               input int cap, output int tries);
    logic [31:0] i, rem, best, best_err, bound;
    best_err = count / lim + 1;
    best = 0;
    bound = count / SEARCH_DIV;
    tries = 0;
    for (i = count / lim + 1; i < bound; i++) begin
      tries++;
      if (cap > 0 && tries > cap) return 0;
      rem = count - (count / i) * i;
      if (rem <= 1) begin
        best = i;
        break;
      end
      if (rem < best_err) begin
        best_err = rem;
        best = i;
      end
    end
    return best;
  endfunction

  function automatic logic [31:0] tick_count(input logic [31:0] timeout);
    logic [31:0] c;
    c = timeout / tick_period();
    return (c == 0) ? 32'd1 : c;
  endfunction

  // Number of divisors the search would try for this timeout.
  function automatic int search_cost(input logic [31:0] timeout);
    logic [31:0] c, lim;
    int tries;
    c = tick_count(timeout);
    lim = eff_limit();
    if (c < lim || c % lim == 0) return 0;
    void'(find_divisor(c, lim, MAX_TRIES, tries));
    return tries;
  endfunction

  // Advances the predicted state by one request and queues its result.
  task automatic timer_predict(input tsit_in_t req);
    tsit_out_t   res;
    logic [31:0] tp, lim, cnt, reload, best, c;
    int          tries;
    res = '0;
    tp = tick_period();
    case (req.command)
      CMD_SET: begin
        res.stop_counter = 1'b1;
        ovf_total = 0;
        lim = eff_limit();
        cnt = tick_count(req.timeout_us);
        if (cnt < lim) begin
          ovf_per_timeout = 1;
          period_us = cnt * tp;
          reload = cnt;
        end else if (cnt % lim == 0) begin
          ovf_per_timeout = cnt / lim;
          period_us = lim * tp;
          reload = lim;
        end else begin
          best = find_divisor(cnt, lim, 0, tries);
          ovf_per_timeout = best;
          period_us = (best == 0) ? 32'd0 : (cnt / best) * tp;
          reload = (best == 0) ? 32'd0 : cnt / best;
        end
        ovf_left = ovf_per_timeout;
        if (ovf_left == 0) begin
          res.invalid = 1'b1;
        end else begin
          res.start_counter = 1'b1;
          res.reload_ticks = reload;
        end
      end
      CMD_TICK: begin
        ovf_total = ovf_total + 1;
        ovf_left = ovf_left - 1;
        if (ovf_left == 0) begin
          ovf_left = ovf_per_timeout;
          ovf_total = 0;
          res.stop_counter = one_shot;
          res.expired = 1'b1;
        end
      end
      CMD_READ: begin
        c = counts_down ? (period_us / tp - req.hw_count) : req.hw_count;
        res.elapsed_us = ovf_total * period_us + c * tp;
      end
      default: ;
    endcase
    pending_results.push_back(res);
  endtask

  // Sends one request; valid stays high across back-to-back requests.
  task automatic send_request(input logic [1:0] cmd, input logic [31:0] timeout,
                              input logic [31:0] hw);
    tsit_in_t req;
    int gap;
    logic taken;
    req.command = cmd;
    req.timeout_us = timeout;
    req.hw_count = hw;
    gap = send_gaps ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    timer_predict(req);
  endtask

  // Writes one register; the caller drops the write enable afterwards.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      REG_FREQ:  freq_hz = value[19:0];
      REG_LIMIT: limit = value;
      REG_ONE:   one_shot = value[0];
      REG_DOWN:  counts_down = value[0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [31:0] f, input logic [31:0] lim,
                           input logic one, input logic down);
    write_reg(REG_FREQ, f);
    write_reg(REG_LIMIT, lim);
    write_reg(REG_ONE, {31'd0, one});
    write_reg(REG_DOWN, {31'd0, down});
    cfg_we <= 1'b0;
  endtask

  // Lets every expected result arrive and the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  // Result side: random stalls, then compare against the oldest prediction.
  initial begin
    int stall;
    logic got;
    tsit_out_t act, exp_res;
    @(posedge clk);
    wait (rst_n);
    forever begin
      stall = recv_stalls ? $urandom_range(0, 13) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk);
        got = out_valid;
        act = out_data;
        @(posedge clk);
      end while (!got);
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", act);
      end else begin
        exp_res = pending_results.pop_front();
        if (act.start_counter !== exp_res.start_counter ||
            act.stop_counter !== exp_res.stop_counter ||
            act.reload_ticks !== exp_res.reload_ticks ||
            act.expired !== exp_res.expired ||
            act.elapsed_us !== exp_res.elapsed_us ||
            act.invalid !== exp_res.invalid) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp_res, act);
        end
      end
    end
  end

  // Extremes of each field and each special case of the split.
  task automatic test_directed();
    send_request(CMD_TICK, 0, 0);              // tick with nothing armed
    send_request(CMD_READ, 0, 32'hFFFF_FFFF);
    send_request(CMD_SET, 0, 0);               // zero count raised to one
    send_request(CMD_TICK, 0, 0);
    send_request(CMD_SET, 100, 0);
    send_request(CMD_READ, 0, 37);
    send_request(CMD_TICK, 0, 0);
    send_request(CMD_SET, 32'd262140, 0);      // divides evenly by the limit
    send_request(CMD_TICK, 0, 0);
    send_request(CMD_READ, 0, 1234);
    send_request(CMD_SET, 32'd70001, 0);       // divisor search, remainder of one
    send_request(CMD_SET, 32'hFFFF_FFFF, 0);
    send_request(CMD_BAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();
    configure(1000000, 10, 1, 1);
    send_request(CMD_SET, 11, 0);              // no divisor can be found
    send_request(CMD_READ, 0, 5);
    send_request(CMD_SET, 5, 0);
    send_request(CMD_READ, 0, 2);              // down-count read
    send_request(CMD_READ, 0, 32'hFFFF_FFFF);
    send_request(CMD_TICK, 0, 0);              // one-shot expiry
    send_request(CMD_SET, 37, 0);              // least-remainder search
    drain();
  endtask

  task automatic random_items(input int n);
    int r, k;
    logic [31:0] t, tp, lim;
    logic [63:0] span;
    for (int j = 0; j < n; j++) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        tp = tick_period();
        lim = eff_limit();
        for (int a = 0; a < 20; a++) begin
          k = $urandom_range(0, 3);
          if (k == 0) begin
            t = $urandom();
          end else if (k == 1) begin
            span = 64'(lim) * tp * 3;
            t = $urandom_range(0, (span > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : span[31:0]);
          end else if (k == 2) begin
            span = 64'(lim) * tp * $urandom_range(1, 6);
            t = span[31:0];
          end else begin
            t = $urandom_range(0, 64) * tp;
          end
          if (search_cost(t) <= MAX_TRIES) break;
          t = tp;
        end
        send_request(CMD_SET, t, $urandom());
      end else if (r < 70) begin
        send_request(CMD_TICK, $urandom(), $urandom());
      end else if (r < 95) begin
        send_request(CMD_READ, $urandom(), $urandom());
      end else begin
        send_request(CMD_BAD, $urandom(), $urandom());
      end
    end
    drain();
  endtask

  // Random traffic under a series of register settings, extremes included.
  task automatic test_settings();
    logic [31:0] freqs[7] = '{1000000, 1, 0, 20'hFFFFF, 1000, 250000, 1000000};
    logic [31:0] lims[7]  = '{65535, 1, 0, 32'hFFFF_FFFF, 1000, 7, 100};
    for (int p = 0; p < 7; p++) begin
      configure(freqs[p], lims[p], p[0], p[1]);
      send_gaps = (p != 3);
      recv_stalls = (p != 4);
      random_items(ITEMS_PER_PHASE);
    end
  endtask

  initial begin
    freq_hz = 20'd1000000;
    limit = 32'd65535;
    one_shot = 1'b0;
    counts_down = 1'b0;
    ovf_total = 0;
    ovf_left = 0;
    ovf_per_timeout = 0;
    period_us = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_settings();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("timeout_split_interval_timer_tb OK");
    end else begin
      $display("timeout_split_interval_timer_tb NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire

### sim.f
design/tsit_pkg.sv
design/tsit_div.sv
design/tsit_dp.sv
design/tsit_ctrl.sv
design/timeout_split_interval_timer.sv
design/tsit_checker.sv
tb/timeout_split_interval_timer_tb.sv
